>>> src/chained_hash_map_engine_core_macros.svh
// Assertion macros for the chained hash map engine.
`ifndef CHAINED_HASH_MAP_ENGINE_CORE_MACROS_SVH
`define CHAINED_HASH_MAP_ENGINE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define CHME_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("chme check failed");
// Next-cycle implication, disabled during reset.
`define CHME_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("chme check failed");
`else
`define CHME_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define CHME_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> src/chme_pkg.sv
// Constants and types shared by the chained hash map engine.
`default_nettype none
package chme_pkg;
	localparam int CAPACITY      = 32;
	localparam int IDX_W         = $clog2(CAPACITY);
	localparam int LINK_W        = IDX_W + 1;
	localparam int COUNT_W       = $clog2(CAPACITY + 1);
	localparam int KEY_W         = 32;
	localparam int VALUE_W       = 32;
	localparam int ENTRY_COUNT_W = 6;
	localparam int OP_W          = 2;

	localparam int S_TDATA_W = KEY_W + VALUE_W;
	localparam int S_TUSER_W = OP_W;
	localparam int M_TDATA_W = ((1 + VALUE_W + ENTRY_COUNT_W + 1 + 7) / 8) * 8;

	typedef logic [LINK_W-1:0]  link_t;
	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [OP_W-1:0]    op_t;

	localparam link_t NIL_LINK = LINK_W'(CAPACITY);

	localparam op_t OP_PUT    = 2'd0;
	localparam op_t OP_GET    = 2'd1;
	localparam op_t OP_REMOVE = 2'd2;
	localparam op_t OP_CLEAR  = 2'd3;
endpackage
`default_nettype wire

>>> src/chained_hash_map_engine_core.sv
// Top level of the chained hash map engine: sequencer, entry pool and result register.
//
//   channel   dir  fields (lowest bit first)
//   s_*       in   tuser: operation; tdata: key_hash, data_value
//   m_*       out  tdata: found, value_out, entry_count, status (zero padded)
//
// Steps per word: get/remove/put read the bucket head, then walk the chain one entry at
// a time (a hit stops on its entry), then unlink a hit for remove/put and insert for put,
// then respond; clear rewrites one link per cycle over the whole pool, then responds.
// The single chain walker does one link and one hash compare a cycle.
// Reset: asynchronous; link pool and bucket valid bits are set at once, no sweep.
// s_tready is high only while the sequencer is idle; a finished result waits in the
// output register, and the next word is taken while it waits.
`default_nettype none
`include "chained_hash_map_engine_core_macros.svh"
module chained_hash_map_engine_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [chme_pkg::S_TDATA_W-1:0] s_tdata,  // key_hash, data_value
	input  logic [chme_pkg::S_TUSER_W-1:0] s_tuser,  // operation
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [chme_pkg::M_TDATA_W-1:0] m_tdata   // found, value_out, entry_count, status
);
	import chme_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_HEAD   = 3'd1;
	localparam logic [2:0] ST_WALK   = 3'd2;
	localparam logic [2:0] ST_UNLINK = 3'd3;
	localparam logic [2:0] ST_INSERT = 3'd4;
	localparam logic [2:0] ST_CLEAR  = 3'd5;
	localparam logic [2:0] ST_RESP   = 3'd6;

	// Entry pool and bucket table, each read at one address a cycle.
	logic [KEY_W-1:0]   entry_hash_q  [CAPACITY];
	logic [VALUE_W-1:0] entry_value_q [CAPACITY];
	link_t              entry_link_q  [CAPACITY];
	link_t              bucket_head_q [CAPACITY];
	logic [CAPACITY-1:0] head_valid_q;

	logic [2:0]         state_q;
	op_t                op_q;
	logic [KEY_W-1:0]   hash_q;
	logic [VALUE_W-1:0] data_q;
	link_t              cur_q;
	link_t              prev_q;
	idx_t               at_q;
	count_t             steps_q;
	count_t             count_q;
	link_t              free_head_q;
	idx_t               clr_idx_q;
	logic               found_q;
	logic [VALUE_W-1:0] value_q;
	logic               status_q;
	logic               m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	idx_t  bucket;
	idx_t  cur_idx;
	idx_t  prev_idx;
	idx_t  free_idx;
	link_t head_rd;
	link_t at_link;
	logic  cur_live;
	logic  hash_hit;
	logic  table_full;
	logic  out_free;
	logic  resp_fire;
	logic  in_accept;
	logic  clr_last;

	// Bucket is the low hash bits.
	assign bucket     = hash_q[IDX_W-1:0];
	assign head_rd    = head_valid_q[bucket] ? bucket_head_q[bucket] : NIL_LINK;
	assign cur_idx    = cur_q[IDX_W-1:0];
	assign prev_idx   = prev_q[IDX_W-1:0];
	assign free_idx   = free_head_q[IDX_W-1:0];
	assign at_link    = entry_link_q[at_q];
	// Stop the walk on a null link or after a full pool of steps.
	assign cur_live   = (cur_q < NIL_LINK) && (steps_q < COUNT_W'(CAPACITY));
	assign hash_hit   = entry_hash_q[cur_idx] == hash_q;
	assign table_full = (count_q >= COUNT_W'(CAPACITY)) || (free_head_q >= NIL_LINK);
	assign out_free   = !m_tvalid_q || m_tready;
	assign resp_fire  = (state_q == ST_RESP) && out_free;
	assign in_accept  = s_tvalid && s_tready;
	assign clr_last   = clr_idx_q == IDX_W'(CAPACITY - 1);

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Sequencer and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_GET;
			hash_q      <= '0;
			data_q      <= '0;
			cur_q       <= NIL_LINK;
			prev_q      <= NIL_LINK;
			at_q        <= '0;
			steps_q     <= '0;
			count_q     <= '0;
			free_head_q <= '0;
			clr_idx_q   <= '0;
			found_q     <= 1'b0;
			value_q     <= '0;
			status_q    <= 1'b0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
		end else begin
			// Raise the result as the response step fires, else drop it once taken.
			if (resp_fire)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						op_q     <= s_tuser;
						hash_q   <= s_tdata[KEY_W-1:0];
						data_q   <= s_tdata[KEY_W +: VALUE_W];
						prev_q   <= NIL_LINK;
						steps_q  <= '0;
						found_q  <= 1'b0;
						value_q  <= '0;
						status_q <= 1'b0;
						clr_idx_q <= '0;
						state_q  <= (s_tuser == OP_CLEAR) ? ST_CLEAR : ST_HEAD;
					end
				end
				ST_HEAD: begin
					cur_q   <= head_rd;
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (cur_live) begin
						if (hash_hit) begin
							found_q <= 1'b1;
							at_q    <= cur_idx;
							if (op_q == OP_GET) begin
								value_q <= entry_value_q[cur_idx];
								state_q <= ST_RESP;
							end else begin
								state_q <= ST_UNLINK;
							end
						end else begin
							// Advance along the chain.
							prev_q  <= cur_q;
							cur_q   <= entry_link_q[cur_idx];
							steps_q <= COUNT_W'(steps_q + 1'b1);
						end
					end else begin
						state_q <= (op_q == OP_PUT) ? ST_INSERT : ST_RESP;
					end
				end
				ST_UNLINK: begin
					free_head_q <= LINK_W'(at_q);
					if (count_q != '0)
						count_q <= COUNT_W'(count_q - 1'b1);
					if (op_q == OP_REMOVE)
						value_q <= entry_value_q[at_q];
					state_q <= (op_q == OP_PUT) ? ST_INSERT : ST_RESP;
				end
				ST_INSERT: begin
					if (table_full) begin
						status_q <= 1'b1;
					end else begin
						free_head_q <= entry_link_q[free_idx];
						count_q     <= COUNT_W'(count_q + 1'b1);
						value_q     <= data_q;
					end
					state_q <= ST_RESP;
				end
				ST_CLEAR: begin
					if (clr_last) begin
						free_head_q <= '0;
						count_q     <= '0;
						state_q     <= ST_RESP;
					end else begin
						clr_idx_q <= IDX_W'(clr_idx_q + 1'b1);
					end
				end
				ST_RESP: begin
					// Hold until the output register is free.
					if (resp_fire) begin
						m_tdata_q  <= M_TDATA_W'({status_q, ENTRY_COUNT_W'(count_q),
							value_q, found_q});
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Link pool: reset and clear rebuild the free list in index order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CAPACITY; i++)
				entry_link_q[i] <= (i + 1 < CAPACITY) ? LINK_W'(i + 1) : NIL_LINK;
		end else begin
			unique case (state_q)
				ST_UNLINK: begin
					if (prev_q < NIL_LINK)
						entry_link_q[prev_idx] <= at_link;
					entry_link_q[at_q] <= free_head_q;
				end
				ST_INSERT: begin
					if (!table_full)
						entry_link_q[free_idx] <= head_rd;
				end
				ST_CLEAR: begin
					entry_link_q[clr_idx_q] <= clr_last ? NIL_LINK :
						LINK_W'(LINK_W'(clr_idx_q) + 1'b1);
				end
				default: ;
			endcase
		end
	end

	// Bucket valid bits: an invalid bucket reads as empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= '0;
		end else if (state_q == ST_CLEAR && clr_last) begin
			head_valid_q <= '0;
		end else if ((state_q == ST_UNLINK && !(prev_q < NIL_LINK)) ||
				(state_q == ST_INSERT && !table_full)) begin
			head_valid_q[bucket] <= 1'b1;
		end
	end

	// Bucket heads and entry payload.
	always_ff @(posedge clk) begin
		if (state_q == ST_UNLINK && !(prev_q < NIL_LINK))
			bucket_head_q[bucket] <= at_link;
		if (state_q == ST_INSERT && !table_full) begin
			bucket_head_q[bucket]   <= free_head_q;
			entry_hash_q[free_idx]  <= hash_q;
			entry_value_q[free_idx] <= data_q;
		end
	end

	// The free list is empty exactly when the pool is full.
	`CHME_ASSERT_NOW(a_free_matches_count, clk, arst_n, 1'b1, (free_head_q == NIL_LINK) == (count_q == COUNT_W'(CAPACITY)))
	// Clear leaves an empty map with the free list from entry zero.
	`CHME_ASSERT_NEXT(a_clear_empties, clk, arst_n, state_q == ST_CLEAR && clr_last, count_q == '0 && free_head_q == '0)
	// A result appears only from the response step.
	`CHME_ASSERT_NOW(a_result_source, clk, arst_n, $rose(m_tvalid_q), $past(state_q) == ST_RESP)
	// Get never changes the stored count.
	`CHME_ASSERT_NEXT(a_get_keeps_count, clk, arst_n, state_q != ST_IDLE && op_q == OP_GET, $stable(count_q))
endmodule
`default_nettype wire

>>> dv/tb_chained_hash_map_engine_core.sv
// Self-checking testbench for the chained hash map engine: directed table, then random traffic.
`default_nettype none
module tb_chained_hash_map_engine_core;
	import chme_pkg::*;

	// Result word as it sits in m_tdata, lowest bit last in this list.
	typedef struct packed {
		logic                     status;
		logic [ENTRY_COUNT_W-1:0] count;
		logic [VALUE_W-1:0]       value;
		logic                     found;
	} map_result_t;

	typedef struct {
		op_t               op;
		logic [KEY_W-1:0]  key;
		logic [VALUE_W-1:0] val;
		bit                typed;
		map_result_t       res;
	} stim_row_t;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int TAIL_CYCLES  = 40;   // quiet tail after the last result, before the report
	localparam int PHASE_WORDS  = 480;
	localparam int POOL_SIZE    = 64;
	localparam int N_DIRECTED   = 15;
	localparam map_result_t ALL_ZERO = '0;

	// Directed words. Typed results are in field order status, count, value, found.
	stim_row_t directed_rows [N_DIRECTED] = '{
		'{OP_GET,    32'h0000_0000, 32'h0000_0000, 1'b1, ALL_ZERO},
		'{OP_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ALL_ZERO},
		'{OP_PUT,    32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 6'd1, 32'd0, 1'b0}},
		'{OP_PUT,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, ALL_ZERO},
		'{OP_PUT,    32'h0000_0020, 32'h1234_5678, 1'b0, ALL_ZERO},
		'{OP_PUT,    32'h0000_0040, 32'hA5A5_5A5A, 1'b0, ALL_ZERO},
		'{OP_GET,    32'h0000_0020, 32'h0000_0000, 1'b0, ALL_ZERO},
		'{OP_PUT,    32'h0000_0020, 32'h8765_4321, 1'b0, ALL_ZERO},
		'{OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b0, ALL_ZERO},
		'{OP_GET,    32'h0000_0000, 32'h0000_0000, 1'b0, ALL_ZERO},
		'{OP_REMOVE, 32'h0000_0040, 32'h0000_0000, 1'b0, ALL_ZERO},
		'{OP_GET,    32'hFFFF_FFFF, 32'h0000_0000, 1'b0, ALL_ZERO},
		'{OP_PUT,    32'h0000_001F, 32'h0000_0000, 1'b0, ALL_ZERO},
		'{OP_CLEAR,  32'hDEAD_BEEF, 32'hFFFF_FFFF, 1'b1, ALL_ZERO},
		'{OP_GET,    32'hFFFF_FFFF, 32'h0000_0000, 1'b1, ALL_ZERO}
	};

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;  // key_hash, data_value
	logic [S_TUSER_W-1:0] s_tuser  = '0;  // operation
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;   // found, value_out, entry_count, status

	chained_hash_map_engine_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the map: chains, entry pool and free list.
	link_t              bucket_first [CAPACITY];
	logic [KEY_W-1:0]   slot_key     [CAPACITY];
	logic [VALUE_W-1:0] slot_value   [CAPACITY];
	link_t              slot_next    [CAPACITY];
	link_t              free_first;
	count_t             occupancy;

	map_result_t pending_results [$];
	logic [KEY_W-1:0] key_pool [POOL_SIZE];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatch_count = 0;
	int results_seen = 0;
	int words_sent = 0;
	int cycle_count = 0;

	function automatic void map_rebuild();
		for (int i = 0; i < CAPACITY; i++) begin
			slot_next[i]    = (i + 1 < CAPACITY) ? link_t'(i + 1) : NIL_LINK;
			bucket_first[i] = NIL_LINK;
		end
		free_first = '0;
		occupancy  = '0;
	endfunction

	// Take an entry off its chain and hand it back to the free list.
	function automatic logic [VALUE_W-1:0] map_unlink(idx_t b, link_t at, link_t prior);
		if (prior < CAPACITY)
			slot_next[prior] = slot_next[at];
		else
			bucket_first[b] = slot_next[at];
		slot_next[at] = free_first;
		free_first = at;
		if (occupancy > 0)
			occupancy--;
		return slot_value[at];
	endfunction

	function automatic map_result_t map_apply(op_t op, logic [KEY_W-1:0] key,
			logic [VALUE_W-1:0] val);
		map_result_t        res;
		idx_t               b;
		link_t              cur, prior, at, fresh;
		int                 steps;
		bit                 hit;
		res = '0;
		b = idx_t'(key % CAPACITY);
		if (op == OP_CLEAR) begin
			map_rebuild();
		end else begin
			hit = 1'b0;
			cur = bucket_first[b];
			prior = NIL_LINK;
			at = NIL_LINK;
			steps = 0;
			// Walk the chain; give up on a null link or after a full pool's worth of steps.
			while (!hit && cur < CAPACITY && steps < CAPACITY) begin
				if (slot_key[cur] == key) begin
					hit = 1'b1;
					at = cur;
				end else begin
					prior = cur;
					cur = slot_next[cur];
					steps++;
				end
			end
			res.found = hit;
			case (op)
				OP_GET: begin
					if (hit)
						res.value = slot_value[at];
				end
				OP_REMOVE: begin
					if (hit)
						res.value = map_unlink(b, at, prior);
				end
				OP_PUT: begin
					// Drop any old copy first, so a present key still fits in a full pool.
					if (hit)
						void'(map_unlink(b, at, prior));
					if (occupancy >= CAPACITY || free_first >= CAPACITY) begin
						res.status = 1'b1;
					end else begin
						fresh = free_first;
						free_first = slot_next[fresh];
						slot_next[fresh] = bucket_first[b];
						bucket_first[b] = fresh;
						slot_key[fresh] = key;
						slot_value[fresh] = val;
						occupancy++;
						res.value = val;
					end
				end
				default: ;
			endcase
		end
		res.count = ENTRY_COUNT_W'(occupancy);
		return res;
	endfunction

	// Offer one word, idling at random first; queue its result once it is taken.
	task automatic send_word(op_t op, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] val,
			bit typed, map_result_t typed_res);
		map_result_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {val, key};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = map_apply(op, key, val);
		pending_results.push_back(typed ? typed_res : predicted);
		words_sent++;
	endtask

	// Hold the input quiet until every outstanding result has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		return ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("result %0d: %s expected %h, got %h", results_seen, field, want, got);
	endtask

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_chained_hash_map_engine_core: errors");
			$finish;
		end
	end

	// Compare each returned word with the oldest outstanding prediction.
	always @(posedge clk) begin : check_results
		map_result_t got;
		map_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = map_result_t'(m_tdata);
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word, value", '0, got.value);
			end else begin
				want = pending_results.pop_front();
				if (got.found !== want.found)
					report_mismatch("found", want.found, got.found);
				if (got.value !== want.value)
					report_mismatch("value_out", want.value, got.value);
				if (got.count !== want.count)
					report_mismatch("entry_count", want.count, got.count);
				if (got.status !== want.status)
					report_mismatch("status", want.status, got.status);
			end
			results_seen++;
		end
	end

	initial begin : stimulus
		logic [KEY_W-1:0] k, last_key;
		int r, guard;
		for (int i = 0; i < CAPACITY; i++) begin
			slot_key[i] = '0;
			slot_value[i] = '0;
		end
		map_rebuild();
		// Half the pool crowds into four buckets to build long chains.
		for (int i = 0; i < POOL_SIZE; i++) begin
			k = $urandom;
			if (i < POOL_SIZE / 2)
				k[IDX_W-1:0] = idx_t'($urandom_range(3));
			key_pool[i] = k;
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_word(directed_rows[i].op, directed_rows[i].key, directed_rows[i].val,
				directed_rows[i].typed, directed_rows[i].res);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 57 : 0;
			recv_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 14 : 0;
			while (words_sent < N_DIRECTED + PHASE_WORDS * (phase + 1)) begin
				if ($urandom_range(99) < 25) begin
					// Fill the pool, overflow it with new keys, then rewrite a present one.
					guard = 0;
					last_key = key_pool[0];
					while (occupancy < CAPACITY && guard < 200) begin
						k = key_pool[$urandom_range(POOL_SIZE - 1)];
						send_word(OP_PUT, k, $urandom, 1'b0, ALL_ZERO);
						last_key = k;
						guard++;
					end
					repeat ($urandom_range(2, 4))
						send_word(OP_PUT, $urandom, $urandom, 1'b0, ALL_ZERO);
					send_word(OP_PUT, last_key, $urandom, 1'b0, ALL_ZERO);
					repeat ($urandom_range(3, 8))
						send_word($urandom_range(1) ? OP_GET : OP_REMOVE, pick_key(),
							$urandom, 1'b0, ALL_ZERO);
				end else begin
					repeat (20) begin
						r = $urandom_range(99);
						send_word((r < 45) ? OP_PUT : (r < 70) ? OP_GET :
							(r < 97) ? OP_REMOVE : OP_CLEAR,
							pick_key(), $urandom, 1'b0, ALL_ZERO);
					end
				end
			end
			if (phase == 0)
				drain_results();
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_chained_hash_map_engine_core: clean");
		else
			$display("tb_chained_hash_map_engine_core: errors");
		$finish;
	end
endmodule
`default_nettype wire

>>> chained_hash_map_engine_core.f
+incdir+src
src/chme_pkg.sv
src/chained_hash_map_engine_core.sv
dv/tb_chained_hash_map_engine_core.sv
